### rtl/fdr_pkg.sv
`default_nettype none
package fdr_pkg;
    localparam int unsigned MAX_VALUES_DEF = 1024;
    localparam logic [31:0] ALPHA_RESET = 32'd107374182;
    localparam logic [1:0] ADDR_SIGNIFICANCE_LEVEL = 2'd0;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SHIFT  = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_CMP    = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, start insertion
        logic shift_rd;  // read entry pos-1
        logic shift_wr;  // move entry up or place value
        logic div_start; // start alpha*k/n division
        logic rd_rank;   // read store at rank index
        logic take;      // accept bound as result
        logic next_rank; // advance rank
        logic finish;    // latch result, clear set
        logic drop;      // item did not fit
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ins_done;  // insertion position found
        logic div_busy;
        logic below;     // p-value at rank below bound
        logic ranks_done;
        logic first_rank;
        logic full;
    } sts_t;
endpackage
`default_nettype wire

### rtl/fdr_threshold_from_pvalues.sv
`default_nettype none
// Channel   | Signals                                  | Direction
// input     | valid, stall, p_value, last_value        | in (stall out)
// result    | out_valid, out_stall, fdr_bound,         | out (out_stall in)
//           | values_used, overflow                    |
// config    | APB psel/penable/pwrite/paddr/pwdata     | in
// A stored item is accepted, then a read and a write step repeat, once per stored
// value it moves past and once to place it; a dropped item is only accepted.
// The last item then starts the scan: per rank a divide start, the divide steps and
// a compare, stopping at the first p-value at or above its bound, then a finish.
// Reset clears counts and flags; the p-value memory is not cleared.
// A new result stalls the input until the previous result beat is taken.
module fdr_threshold_from_pvalues
#(
    parameter int unsigned MAX_VALUES = fdr_pkg::MAX_VALUES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             stall,
    input  wire logic [31:0] p_value,
    input  wire logic        last_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      fdr_bound,
    output logic [10:0]      values_used,
    output logic             overflow,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    fdr_pkg::cmd_t cmd;
    fdr_pkg::sts_t sts;
    logic [31:0] alpha_reg;
    logic in_fire, out_taken;

    assign pready = 1'b1;
    assign in_fire = valid && !stall;
    assign out_taken = out_valid && !out_stall;
    assign prdata = (paddr == fdr_pkg::ADDR_SIGNIFICANCE_LEVEL) ? alpha_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= fdr_pkg::ALPHA_RESET;
        else if (psel && penable && pwrite && paddr == fdr_pkg::ADDR_SIGNIFICANCE_LEVEL)
            alpha_reg <= pwdata;
    end

    fdr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .last_value (last_value),
        .out_taken  (out_taken),
        .sts        (sts),
        .cmd        (cmd),
        .in_stall   (stall),
        .out_valid  (out_valid)
    );

    fdr_datapath #(.MAX_VALUES(MAX_VALUES)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .p_value     (p_value),
        .alpha       (alpha_reg),
        .fdr_bound   (fdr_bound),
        .values_used (values_used),
        .overflow    (overflow)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start |-> stall)) else $error("division while accepting");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift_wr && cmd.finish)) else $error("insert during finish");
endmodule
`default_nettype wire

### rtl/fdr_divider.sv
`default_nettype none
// Restoring divider: 64-bit dividend by 17-bit divisor, one quotient bit a cycle.
module fdr_divider
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [16:0] divisor,
    output logic             busy,
    output logic [63:0]      quotient
);
    logic [63:0] q_reg, q_next;
    logic [16:0] r_reg, r_next, d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [17:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[63]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                r_next = trial[16:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[15:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

### rtl/fdr_datapath.sv
`default_nettype none
module fdr_datapath
#(
    parameter int unsigned MAX_VALUES = fdr_pkg::MAX_VALUES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire fdr_pkg::cmd_t cmd,
    output fdr_pkg::sts_t     sts,
    input  wire logic [31:0]  p_value,
    input  wire logic [31:0]  alpha,
    output logic [31:0]       fdr_bound,
    output logic [10:0]       values_used,
    output logic              overflow
);
    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);

    logic [31:0] mem [MAX_VALUES];
    logic [31:0] rd_data_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] rank_reg, rank_next;
    logic [31:0] pin_reg;
    logic [31:0] result_reg, result_next;
    logic        dropped_reg, dropped_next;
    logic [31:0] out_bound_reg;
    logic [10:0] out_used_reg;
    logic        out_ovf_reg;
    logic        div_busy;
    logic [63:0] quot;
    logic [63:0] dividend;
    logic [CW-1:0] rd_idx;
    logic [CW-1:0] wr_idx;
    logic [31:0] wr_data;
    logic [CW:0] k_mul;

    // rank k of the scan gives the bound k*alpha/n; rank 1 is alpha/n
    assign k_mul = {1'b0, rank_reg};
    assign dividend = {32'd0, alpha} * {{(64 - CW - 1){1'b0}}, k_mul};

    fdr_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (17'(count_reg)),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_comb
    begin
        rd_idx = cmd.rd_rank ? CW'(rank_reg - CW'(1)) : CW'(pos_reg - CW'(1));
        wr_idx = pos_reg;
        wr_data = (pos_reg != '0 && rd_data_reg > pin_reg) ? rd_data_reg : pin_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_rd || cmd.rd_rank)
            rd_data_reg <= mem[rd_idx[AW-1:0]];
        if (cmd.shift_wr)
        begin
            if (wr_data == rd_data_reg && pos_reg != '0 && rd_data_reg > pin_reg)
                mem[wr_idx[AW-1:0]] <= rd_data_reg;
            else
                mem[wr_idx[AW-1:0]] <= pin_reg;
        end
        if (cmd.load)
            pin_reg <= p_value;
    end

    always_comb
    begin
        count_next = count_reg;
        pos_next = pos_reg;
        rank_next = rank_reg;
        result_next = result_reg;
        dropped_next = dropped_reg;
        if (cmd.load)
            pos_next = count_reg;
        if (cmd.drop)
            dropped_next = 1'b1;
        if (cmd.shift_wr)
        begin
            if (pos_reg != '0 && rd_data_reg > pin_reg)
                pos_next = pos_reg - CW'(1);
            else
                count_next = count_reg + CW'(1);
        end
        if (cmd.take)
            result_next = quot[31:0];
        if (cmd.next_rank)
            rank_next = rank_reg + CW'(1);
        if (cmd.finish)
        begin
            count_next = '0;
            dropped_next = 1'b0;
            rank_next = CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dropped_reg <= 1'b0;
            pos_reg <= '0;
            rank_reg <= CW'(1);
        end
        else
        begin
            count_reg <= count_next;
            dropped_reg <= dropped_next;
            pos_reg <= pos_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.finish)
        begin
            out_bound_reg <= result_reg;
            out_used_reg <= 11'(count_reg);
            out_ovf_reg <= dropped_reg;
        end
    end

    always_comb
    begin
        sts.ins_done = !(pos_reg != '0 && rd_data_reg > pin_reg);
        sts.div_busy = div_busy;
        sts.below = {32'd0, rd_data_reg} < quot;
        sts.ranks_done = (rank_reg == count_reg);
        sts.first_rank = (rank_reg == CW'(1));
        sts.full = (count_reg >= CW'(MAX_VALUES));
    end

    assign fdr_bound = out_bound_reg;
    assign values_used = out_used_reg;
    assign overflow = out_ovf_reg;
endmodule
`default_nettype wire

### rtl/fdr_ctrl.sv
`default_nettype none
module fdr_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          last_value,
    input  wire logic          out_taken,
    input  wire fdr_pkg::sts_t sts,
    output fdr_pkg::cmd_t      cmd,
    output logic               in_stall,
    output logic               out_valid
);
    fdr_pkg::state_t state_reg, state_next;
    logic last_reg, last_next;
    logic ovalid_reg, ovalid_next;
    logic div_wait_reg, div_wait_next;

    always_comb
    begin
        state_next = state_reg;
        last_next = last_reg;
        ovalid_next = ovalid_reg;
        div_wait_next = 1'b0;
        cmd = '0;
        if (out_taken)
            ovalid_next = 1'b0;
        case (state_reg)
            fdr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = last_value;
                    if (sts.full)
                    begin
                        cmd.drop = 1'b1;
                        state_next = last_value ? fdr_pkg::ST_DIV : fdr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        state_next = fdr_pkg::ST_SHIFT;
                    end
                end
            end
            fdr_pkg::ST_SHIFT:
            begin
                // read neighbor below, then place or move
                cmd.shift_rd = 1'b1;
                state_next = fdr_pkg::ST_SCAN;
            end
            fdr_pkg::ST_SCAN:
            begin
                cmd.shift_wr = 1'b1;
                if (sts.ins_done)
                    state_next = last_reg ? fdr_pkg::ST_DIV : fdr_pkg::ST_IDLE;
                else
                    state_next = fdr_pkg::ST_SHIFT;
            end
            fdr_pkg::ST_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.rd_rank = 1'b1;
                div_wait_next = 1'b1;
                state_next = fdr_pkg::ST_CMP;
            end
            fdr_pkg::ST_CMP:
            begin
                if (!sts.div_busy && !div_wait_reg)
                begin
                    // rank 1 sets the starting bound alpha/n whatever its p-value
                    cmd.take = sts.below || sts.first_rank;
                    // stop on the first p-value at or above its bound
                    if (sts.below && !sts.ranks_done)
                    begin
                        cmd.next_rank = 1'b1;
                        state_next = fdr_pkg::ST_DIV;
                    end
                    else
                        state_next = fdr_pkg::ST_FIN;
                end
            end
            fdr_pkg::ST_FIN:
            begin
                if (!ovalid_reg || out_taken)
                begin
                    cmd.finish = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = fdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdr_pkg::ST_IDLE;
            last_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
            ovalid_reg <= ovalid_next;
            div_wait_reg <= div_wait_next;
        end
    end

    assign in_stall = (state_reg != fdr_pkg::ST_IDLE);
    assign out_valid = ovalid_reg;
endmodule
`default_nettype wire
